// ----- rtl/mep_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mep_pkg;

  // fixed point layout of the point c and of the working value z
  localparam int IN_W      = 30;
  localparam int FRAC_BITS = 28;
  // z stays within +/-6 while the loop runs, so 32 bits hold it exactly
  localparam int WORK_W    = 32;
  localparam int PROD_W    = 2 * WORK_W;
  localparam int ITER_W    = 16;
  localparam int SHADE_W   = 8;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // register index, taken from paddr above the byte offset
  localparam logic REG_MAX_ITER = 1'b0;

  localparam logic [ITER_W-1:0]  MAX_ITER_RST = ITER_W'(1000);
  localparam logic [SHADE_W-1:0] SHADE_WHITE  = SHADE_W'(255);
  localparam logic [SHADE_W-1:0] SHADE_BLACK  = SHADE_W'(0);

  // 4 at the product scale
  localparam logic signed [PROD_W-1:0] ESC_THRESH =
    PROD_W'(64'sd1 <<< (2 * FRAC_BITS + 2));

  typedef logic signed [WORK_W-1:0] work_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    prod_t rr;
    prod_t ii;
    prod_t ri;
  } mep_prod_t;

endpackage

`default_nettype wire

// ----- rtl/mandelbrot_escape_pixel.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// in_       slave      in_tvalid/in_tready  c_real [29:0], c_imag [59:30]
// out_      master     out_tvalid/out_tready shade [7:0], iterations_done [23:8]
// cfg_      apb        psel/penable/pready  max_iterations at byte address 0
//
// each iteration of z = z*z + c has a multiply cycle in the squaring unit and
// a test-and-update cycle. when an item's result leaves the loop, in_tready
// rises again, so a new item is taken only once the last is out of the loop.
// reset (synchronous, active low) sets max_iterations to 1000 and idles the
// loop; no memory needs clearing. a result not taken holds the loop in its
// test cycle only if the next result is ready before the previous one leaves.

module mandelbrot_escape_pixel
  import mep_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // c_real, c_imag, zero pad

  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // shade, iterations_done

  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_TEST
  } state_t;

  state_t               state_r;
  logic [ITER_W-1:0]    max_iter_r;
  logic [ITER_W-1:0]    count_r;
  logic signed [IN_W-1:0] cr_r;
  logic signed [IN_W-1:0] ci_r;
  work_t                re_r;
  work_t                im_r;
  logic                 out_valid_r;
  logic [SHADE_W-1:0]   shade_r;
  logic [ITER_W-1:0]    iter_out_r;

  mep_prod_t            prod;
  prod_t                mag_sq;
  prod_t                diff;
  prod_t                twice_ri;
  work_t                re_nxt;
  work_t                im_nxt;
  logic                 stop;
  logic                 done;
  logic                 cfg_wr;

  mep_cmul u_cmul (
    .clk    (clk),
    .re     (re_r),
    .im     (im_r),
    .prod_r (prod)
  );

  assign mag_sq   = prod.rr + prod.ii;
  assign diff     = prod.rr - prod.ii;
  assign twice_ri = prod.ri <<< 1;
  assign re_nxt   = WORK_W'(diff >>> FRAC_BITS) + WORK_W'(cr_r);
  assign im_nxt   = WORK_W'(twice_ri >>> FRAC_BITS) + WORK_W'(ci_r);
  assign stop     = (mag_sq > ESC_THRESH) || (count_r >= max_iter_r);
  // result leaves the loop this cycle
  assign done     = (state_r == ST_TEST) && stop && (!out_valid_r || out_tready);

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_ITER) ?
                      CFG_DATA_W'(max_iter_r) : '0;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {iter_out_r, shade_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_iter_r  <= MAX_ITER_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_MAX_ITER) begin
        max_iter_r <= cfg_pwdata[ITER_W-1:0];
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cr_r    <= in_tdata[IN_W-1:0];
            ci_r    <= in_tdata[2*IN_W-1:IN_W];
            re_r    <= '0;
            im_r    <= '0;
            count_r <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_TEST;
        end
        ST_TEST: begin
          if (stop) begin
            // wait here only while the previous item is still unclaimed
            if (!out_valid_r || out_tready) begin
              shade_r     <= (count_r != max_iter_r) ? SHADE_WHITE : SHADE_BLACK;
              iter_out_r  <= count_r;
              state_r     <= ST_IDLE;
            end
          end else begin
            re_r    <= re_nxt;
            im_r    <= im_nxt;
            count_r <= count_r + ITER_W'(1);
            state_r <= ST_MUL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_MUL && count_r == '0)
    else $error("accepted item did not start the loop with a cleared count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      count_r == $past(count_r) + ITER_W'(1) || count_r == '0)
    else $error("iteration count moved by more than one");

  a_count_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) && count_r != '0 |-> $past(state_r) == ST_TEST)
    else $error("iteration count advanced outside the test cycle");

  a_result_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_TEST && state_r == ST_IDLE)
    else $error("result raised outside the test cycle");

endmodule

`default_nettype wire

// ----- rtl/mep_cmul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mep_cmul
  import mep_pkg::*;
(
  input  wire logic      clk,
  input  wire work_t     re,
  input  wire work_t     im,
  output mep_prod_t      prod_r
);

  // squares and cross product of z, registered before the add and compare
  always_ff @(posedge clk) begin
    prod_r.rr <= PROD_W'(re) * PROD_W'(re);
    prod_r.ii <= PROD_W'(im) * PROD_W'(im);
    prod_r.ri <= PROD_W'(re) * PROD_W'(im);
  end

endmodule

`default_nettype wire
